// ----- design/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point-in-polygon filter
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int NUM_VERTICES = 4;
  localparam int VIDX_W       = 2;
  localparam int COORD_W      = 16;
  localparam int COLOR_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int DATA_W       = 3 * COORD_W + COLOR_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = COORD_W;
  localparam int INFLIGHT_W   = 2;

  // low bit of a register index picks the coordinate of a vertex
  localparam logic REG_SEL_X = 1'b0;
  localparam logic REG_SEL_Y = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0]        color;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef vertex_t [NUM_VERTICES-1:0] polygon_t;

  // front to queue: one kept point
  typedef struct packed {
    logic   valid;
    point_t pt;
  } push_t;

  // queue to back: head of the queue
  typedef struct packed {
    logic   empty;
    point_t pt;
  } head_t;

  localparam vertex_t V0_RESET = '{x: -16'sd602, y: 16'sd430};
  localparam vertex_t V1_RESET = '{x: -16'sd730, y: 16'sd411};
  localparam vertex_t V2_RESET = '{x: -16'sd740, y: -16'sd3};
  localparam vertex_t V3_RESET = '{x: -16'sd608, y: -16'sd7};

  localparam polygon_t POLYGON_RESET = {V3_RESET, V2_RESET, V1_RESET, V0_RESET};

endpackage

// ----- design/pip_front.sv -----
// ----------------------------------------------------------------------------
// pip_front
// three-stage classifier: edge differences, cross products, even-odd parity
// ----------------------------------------------------------------------------
module pip_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  pip_pkg::point_t                      in_pt_i,
  input  pip_pkg::polygon_t                    poly_i,
  output pip_pkg::push_t                       push_o,
  output logic [pip_pkg::INFLIGHT_W-1:0]       inflight_o
);

  localparam int NV = pip_pkg::NUM_VERTICES;

  // stage 1: differences and straddle flags
  logic signed [pip_pkg::DIFF_W-1:0] dxp_d [NV];
  logic signed [pip_pkg::DIFF_W-1:0] dyp_d [NV];
  logic signed [pip_pkg::DIFF_W-1:0] dxe_d [NV];
  logic signed [pip_pkg::DIFF_W-1:0] dye_d [NV];
  logic        [NV-1:0]              strad_d;
  logic signed [pip_pkg::DIFF_W-1:0] dxp_q [NV];
  logic signed [pip_pkg::DIFF_W-1:0] dyp_q [NV];
  logic signed [pip_pkg::DIFF_W-1:0] dxe_q [NV];
  logic signed [pip_pkg::DIFF_W-1:0] dye_q [NV];
  logic        [NV-1:0]              s1_strad_q;
  logic                              s1_valid_q;
  pip_pkg::point_t                   s1_pt_q;

  // stage 2: cross products
  logic signed [pip_pkg::PROD_W-1:0] lhs_q [NV];
  logic signed [pip_pkg::PROD_W-1:0] rhs_q [NV];
  logic        [NV-1:0]              s2_neg_q;
  logic        [NV-1:0]              s2_strad_q;
  logic                              s2_valid_q;
  pip_pkg::point_t                   s2_pt_q;

  // stage 3: kept point
  logic [NV-1:0]   cross_d;
  logic            keep_d;
  logic            s3_keep_q;
  pip_pkg::point_t s3_pt_q;

  always_comb begin
    for (int k = 0; k < NV; k++) begin
      // edge runs from vertex k to the previous vertex, wrapping
      dxp_d[k] = {in_pt_i.x[pip_pkg::COORD_W-1], in_pt_i.x}
               - {poly_i[k].x[pip_pkg::COORD_W-1], poly_i[k].x};
      dyp_d[k] = {in_pt_i.y[pip_pkg::COORD_W-1], in_pt_i.y}
               - {poly_i[k].y[pip_pkg::COORD_W-1], poly_i[k].y};
      dxe_d[k] = {poly_i[(k+NV-1)%NV].x[pip_pkg::COORD_W-1], poly_i[(k+NV-1)%NV].x}
               - {poly_i[k].x[pip_pkg::COORD_W-1], poly_i[k].x};
      dye_d[k] = {poly_i[(k+NV-1)%NV].y[pip_pkg::COORD_W-1], poly_i[(k+NV-1)%NV].y}
               - {poly_i[k].y[pip_pkg::COORD_W-1], poly_i[k].y};
      strad_d[k] = (poly_i[k].y > in_pt_i.y) != (poly_i[(k+NV-1)%NV].y > in_pt_i.y);
    end
  end

  always_comb begin
    for (int k = 0; k < NV; k++) begin
      // sign of the edge's y span flips the comparison
      cross_d[k] = s2_strad_q[k] &
                   (s2_neg_q[k] ? (lhs_q[k] > rhs_q[k]) : (lhs_q[k] < rhs_q[k]));
    end
    keep_d = s2_valid_q & (^cross_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_keep_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_keep_q  <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NV; k++) begin
      dxp_q[k]      <= dxp_d[k];
      dyp_q[k]      <= dyp_d[k];
      dxe_q[k]      <= dxe_d[k];
      dye_q[k]      <= dye_d[k];
      lhs_q[k]      <= dxp_q[k] * dye_q[k];
      rhs_q[k]      <= dxe_q[k] * dyp_q[k];
      s2_neg_q[k]   <= dye_q[k][pip_pkg::DIFF_W-1];
    end
    s1_strad_q <= strad_d;
    s2_strad_q <= s1_strad_q;
    s1_pt_q    <= in_pt_i;
    s2_pt_q    <= s1_pt_q;
    s3_pt_q    <= s2_pt_q;
  end

  assign push_o.valid = s3_keep_q;
  assign push_o.pt    = s3_pt_q;

  // items still in flight that may need a queue slot
  assign inflight_o = pip_pkg::INFLIGHT_W'(s1_valid_q) + pip_pkg::INFLIGHT_W'(s2_valid_q)
                    + pip_pkg::INFLIGHT_W'(s3_keep_q);

endmodule

// ----- design/pip_queue.sv -----
// ----------------------------------------------------------------------------
// pip_queue
// small first-in first-out queue of kept points between front and back
// ----------------------------------------------------------------------------
module pip_queue #(
  parameter int DEPTH = 8,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pip_pkg::push_t  push_i,
  input  logic            pop_i,
  output pip_pkg::head_t  head_o,
  output logic [CW-1:0]   count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pip_pkg::point_t slot_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i.valid, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.pt;
    end
  end

  assign head_o.empty = (count_q == '0);
  assign head_o.pt    = slot_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

// ----- design/pip_back.sv -----
// ----------------------------------------------------------------------------
// pip_back
// output register: takes the queue head whenever it is free or being emptied
// ----------------------------------------------------------------------------
module pip_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pip_pkg::head_t               head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pip_pkg::point_t              out_pt_o
);

  logic            valid_q, valid_d;
  pip_pkg::point_t pt_q;

  assign pop_o = !head_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    priority if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pt_q <= head_i.pt;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pt_o    = pt_q;

endmodule

// ----- design/point_in_polygon_filter.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_filter
// path: an accepted item passes the three classifier stages, the queue and the output register
// throughput: one item per cycle through the three-stage classifier, while queue credit allows
// reset: vertex registers load the default polygon, queue and output stage empty
// ----------------------------------------------------------------------------
module point_in_polygon_filter #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // point_x, point_y, point_z, point_color from the lowest bit up
  input  logic [pip_pkg::DATA_W-1:0]         s_axis_tdata,
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // kept_x, kept_y, kept_z, kept_color from the lowest bit up
  output logic [pip_pkg::DATA_W-1:0]         m_axis_tdata,
  // vertex register writes
  input  logic                               cfg_we_i,
  input  logic [pip_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pip_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  pip_pkg::polygon_t                  poly_q;
  pip_pkg::point_t                    in_pt;
  pip_pkg::point_t                    out_pt;
  pip_pkg::push_t                     push;
  pip_pkg::head_t                     head;
  logic                               pop;
  logic                               in_accept;
  logic [pip_pkg::INFLIGHT_W-1:0]     inflight;
  logic [CW-1:0]                      q_count;
  logic [pip_pkg::VIDX_W-1:0]         cfg_vertex;

  // vertex registers: index bit 0 picks x or y, the rest the vertex
  assign cfg_vertex = cfg_index_i[pip_pkg::CFG_IDX_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= pip_pkg::POLYGON_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i[0])
        pip_pkg::REG_SEL_X: poly_q[cfg_vertex].x <= cfg_data_i;
        pip_pkg::REG_SEL_Y: poly_q[cfg_vertex].y <= cfg_data_i;
        default:            poly_q <= poly_q;
      endcase
    end
  end

  // unpack the slave payload, first field in the lowest bits
  assign in_pt = pip_pkg::point_t'(s_axis_tdata);

  // credit: accept only while every item in flight is sure of a queue slot,
  // so the classifier never has to stall
  assign s_axis_tready = (SW'(q_count) + SW'(inflight)) < SW'(QUEUE_DEPTH);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  pip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_accept),
    .in_pt_i    (in_pt),
    .poly_i     (poly_q),
    .push_o     (push),
    .inflight_o (inflight)
  );

  pip_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pt_o    (out_pt)
  );

  assign m_axis_tdata = pip_pkg::DATA_W'(out_pt);

`ifndef NO_ASSERTIONS
  // the credit scheme must keep a push off a full queue
  a_no_push_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (q_count < CW'(QUEUE_DEPTH)))
    else $error("kept point pushed into a full queue");

  // queue occupancy never passes its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // a waiting head moves into an empty output stage at once
  a_back_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!head.empty && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("output stage stayed empty while the queue held an item");
`endif

endmodule

// ----- verif/pip_filter_checker.sv -----
// ----------------------------------------------------------------------------
// pip_filter_checker
// watches both streams and the vertex writes, predicts which points are kept
// and compares every kept point against the oldest prediction
// ----------------------------------------------------------------------------
module pip_filter_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [pip_pkg::DATA_W-1:0]    s_data_i,
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [pip_pkg::DATA_W-1:0]    m_data_i,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pip_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                            errors_o,
  output int                            awaiting_o,
  output int                            points_in_o,
  output int                            points_kept_o
);

  pip_pkg::polygon_t  polygon;
  pip_pkg::point_t    kept_points_q[$];
  pip_pkg::point_t    s_pt;
  pip_pkg::point_t    m_pt;
  pip_pkg::point_t    want;
  int                 mismatches;
  int                 points_in;
  int                 points_kept;

  assign s_pt          = s_data_i;
  assign m_pt          = m_data_i;
  assign errors_o      = mismatches;
  assign awaiting_o    = kept_points_q.size();
  assign points_in_o   = points_in;
  assign points_kept_o = points_kept;

  // even-odd crossing count, exact integer cross-multiplication
  function automatic logic point_is_inside(input pip_pkg::polygon_t poly,
                                           input logic signed [pip_pkg::COORD_W-1:0] px,
                                           input logic signed [pip_pkg::COORD_W-1:0] py);
    logic   odd;
    logic   left;
    int     j;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    odd = 1'b0;
    j   = pip_pkg::NUM_VERTICES - 1;
    for (int i = 0; i < pip_pkg::NUM_VERTICES; i++) begin
      xi = longint'(poly[i].x);
      yi = longint'(poly[i].y);
      xj = longint'(poly[j].x);
      yj = longint'(poly[j].y);
      if ((yi > longint'(py)) != (yj > longint'(py))) begin
        dy   = yj - yi;
        lhs  = (longint'(px) - xi) * dy;
        rhs  = (xj - xi) * (longint'(py) - yi);
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  task automatic check_field(input string field,
                             input logic [pip_pkg::COLOR_W-1:0] exp_val,
                             input logic [pip_pkg::COLOR_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: kept point %0d, %s expected 0x%0h actual 0x%0h",
               $time, points_kept, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polygon     <= pip_pkg::POLYGON_RESET;
      kept_points_q.delete();
      mismatches  = 0;
      points_in   = 0;
      points_kept = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        points_in++;
        if (point_is_inside(polygon, s_pt.x, s_pt.y)) begin
          kept_points_q.insert(kept_points_q.size(), s_pt);
        end
      end
      if (m_valid_i && m_ready_i) begin
        points_kept++;
        if (kept_points_q.size() == 0) begin
          mismatches++;
          $display("%0t: kept point %0d with none expected, actual 0x%0h",
                   $time, points_kept, m_data_i);
        end else begin
          want = kept_points_q.pop_front();
          check_field("x", pip_pkg::COLOR_W'(want.x), pip_pkg::COLOR_W'(m_pt.x));
          check_field("y", pip_pkg::COLOR_W'(want.y), pip_pkg::COLOR_W'(m_pt.y));
          check_field("z", pip_pkg::COLOR_W'(want.z), pip_pkg::COLOR_W'(m_pt.z));
          check_field("colour", want.color, m_pt.color);
        end
      end
      // low index bit picks the coordinate, the rest the vertex
      if (cfg_we_i) begin
        if (cfg_index_i[0] == pip_pkg::REG_SEL_X) begin
          polygon[cfg_index_i[pip_pkg::CFG_IDX_W-1:1]].x <= cfg_data_i;
        end else begin
          polygon[cfg_index_i[pip_pkg::CFG_IDX_W-1:1]].y <= cfg_data_i;
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives coloured points through the point-in-polygon filter under a series
// of polygons (reset default, full-scale square, diamond, bowtie, degenerate
// and random quads) with varied back-pressure; the checker module predicts
// the kept points and this top gives the verdict
// ----------------------------------------------------------------------------
module testbench;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH_IDLE
  } flow_e;

  localparam int QUIET_LIMIT    = 2000;  // cycles with no item moving on either side
  localparam int HOLDOFF_CYCLES = 150;   // long receiver hold-off for the pressure phase
  localparam int SETTLE_CYCLES  = 8;     // block latency plus margin
  localparam int NUM_DIRECTED   = 18;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [pip_pkg::DATA_W-1:0]    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [pip_pkg::DATA_W-1:0]    m_axis_tdata;
  logic                          cfg_we_i      = 1'b0;
  logic [pip_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [pip_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;

  int                errors;
  int                awaiting;
  int                points_in;
  int                points_kept;
  int                sender_idle_pct  = 0;
  int                recv_stall_pct   = 0;
  int                quiet_cycles     = 0;
  int                settings_loaded  = 1;   // reset polygon counts as the first
  int                holdoff_requests = 0;
  pip_pkg::polygon_t poly_now         = pip_pkg::POLYGON_RESET;

  // directed points around the reset polygon: centre, corners of the field,
  // each vertex, rows through vertex y values and points on each edge
  int directed_xy [NUM_DIRECTED][2] = '{
    '{-670, 200}, '{-670, 200},
    '{-602, 430}, '{-730, 411}, '{-740, -3}, '{-608, -7},
    '{-32768, -32768}, '{32767, 32767}, '{-32768, 32767}, '{32767, -32768},
    '{-666, 430}, '{-700, -3}, '{-605, 0},
    '{-666, 420}, '{-735, 204}, '{-674, -5}, '{-605, 211},
    '{0, 0}
  };

  // clock, period 10
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  point_in_polygon_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pip_filter_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .awaiting_o    (awaiting),
    .points_in_o   (points_in),
    .points_kept_o (points_kept)
  );

  // receiver: random stalls, or a long hold-off counted here when asked for
  initial begin : receiver
    int holdoff_left;
    int holdoff_served;
    holdoff_left   = 0;
    holdoff_served = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_served != holdoff_requests) begin
        holdoff_served = holdoff_requests;
        holdoff_left   = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("point_in_polygon_filter verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      default: return 32767;
    endcase
  endfunction

  function automatic pip_pkg::polygon_t quad(input int ax, input int ay,
                                             input int bx, input int by,
                                             input int cx, input int cy,
                                             input int dx, input int dy);
    pip_pkg::polygon_t poly;
    poly[0].x = pip_pkg::COORD_W'(ax); poly[0].y = pip_pkg::COORD_W'(ay);
    poly[1].x = pip_pkg::COORD_W'(bx); poly[1].y = pip_pkg::COORD_W'(by);
    poly[2].x = pip_pkg::COORD_W'(cx); poly[2].y = pip_pkg::COORD_W'(cy);
    poly[3].x = pip_pkg::COORD_W'(dx); poly[3].y = pip_pkg::COORD_W'(dy);
    return poly;
  endfunction

  // random quad within +-span, may well cross itself
  function automatic pip_pkg::polygon_t random_quad(input int span);
    pip_pkg::polygon_t poly;
    for (int v = 0; v < pip_pkg::NUM_VERTICES; v++) begin
      poly[v].x = pip_pkg::COORD_W'(clamp_coord(rand_between(-span, span)));
      poly[v].y = pip_pkg::COORD_W'(clamp_coord(rand_between(-span, span)));
    end
    return poly;
  endfunction

  // point generator: mostly inside the bounding box of the current polygon,
  // some on vertex rows, near vertices, anywhere, or at extremes
  function automatic pip_pkg::point_t pick_point();
    pip_pkg::point_t pt;
    int              lo_x, hi_x, lo_y, hi_y, margin, roll, v;
    lo_x = 32767; hi_x = -32768;
    lo_y = 32767; hi_y = -32768;
    for (int k = 0; k < pip_pkg::NUM_VERTICES; k++) begin
      if (int'(poly_now[k].x) < lo_x) lo_x = int'(poly_now[k].x);
      if (int'(poly_now[k].x) > hi_x) hi_x = int'(poly_now[k].x);
      if (int'(poly_now[k].y) < lo_y) lo_y = int'(poly_now[k].y);
      if (int'(poly_now[k].y) > hi_y) hi_y = int'(poly_now[k].y);
    end
    margin = 8 + (hi_x - lo_x + hi_y - lo_y) / 16;
    lo_x = clamp_coord(lo_x - margin);
    hi_x = clamp_coord(hi_x + margin);
    lo_y = clamp_coord(lo_y - margin);
    hi_y = clamp_coord(hi_y + margin);
    v    = int'($urandom_range(pip_pkg::NUM_VERTICES - 1));
    roll = int'($urandom_range(99));
    pt.z     = pip_pkg::COORD_W'($urandom);
    pt.color = pip_pkg::COLOR_W'($urandom);
    if (roll < 55) begin
      pt.x = pip_pkg::COORD_W'(rand_between(lo_x, hi_x));
      pt.y = pip_pkg::COORD_W'(rand_between(lo_y, hi_y));
    end else if (roll < 70) begin
      // on the row of a vertex, sometimes right on it
      pt.x = pip_pkg::COORD_W'($urandom_range(1) ? int'(poly_now[v].x)
                                                 : rand_between(lo_x, hi_x));
      pt.y = poly_now[v].y;
    end else if (roll < 80) begin
      pt.x = pip_pkg::COORD_W'(clamp_coord(int'(poly_now[v].x) + rand_between(-3, 3)));
      pt.y = pip_pkg::COORD_W'(clamp_coord(int'(poly_now[v].y) + rand_between(-3, 3)));
    end else if (roll < 90) begin
      pt.x = pip_pkg::COORD_W'($urandom);
      pt.y = pip_pkg::COORD_W'($urandom);
    end else begin
      pt.x = pip_pkg::COORD_W'(extreme_coord());
      pt.y = pip_pkg::COORD_W'(extreme_coord());
    end
    return pt;
  endfunction

  task automatic set_flow(input flow_e mode);
    case (mode)
      FLOW_SENDER_IDLE:    begin sender_idle_pct = 68; recv_stall_pct = 0;  end
      FLOW_RECEIVER_STALL: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
      FLOW_BOTH_IDLE:      begin sender_idle_pct = 8;  recv_stall_pct = 8;  end
      default:             begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // one item on the slave side, with random idle cycles before it
  task automatic offer_point(input pip_pkg::point_t pt);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pt;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic run_points(input int count);
    for (int n = 0; n < count; n++) offer_point(pick_point());
    s_axis_tvalid <= 1'b0;
  endtask

  // wait until every kept point is out, then let the pipeline run empty
  task automatic drain_results();
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all eight vertex registers back to back while the block is idle
  task automatic load_polygon(input pip_pkg::polygon_t poly);
    drain_results();
    for (int v = 0; v < pip_pkg::NUM_VERTICES; v++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= {pip_pkg::VIDX_W'(v), pip_pkg::REG_SEL_X};
      cfg_data_i  <= poly[v].x;
      @(posedge clk_i);
      cfg_index_i <= {pip_pkg::VIDX_W'(v), pip_pkg::REG_SEL_Y};
      cfg_data_i  <= poly[v].y;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    poly_now = poly;
    settings_loaded++;
  endtask

  initial begin : stimulus
    pip_pkg::point_t pt;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed points on the reset polygon, field extremes on the first two
    set_flow(FLOW_FREE);
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      pt.x     = pip_pkg::COORD_W'(directed_xy[k][0]);
      pt.y     = pip_pkg::COORD_W'(directed_xy[k][1]);
      pt.z     = (k == 0) ? pip_pkg::COORD_W'(-32768) :
                 (k == 1) ? pip_pkg::COORD_W'(32767)  : pip_pkg::COORD_W'($urandom);
      pt.color = (k == 0) ? '0 : (k == 1) ? '1 : pip_pkg::COLOR_W'($urandom);
      offer_point(pt);
    end
    run_points(60);

    // full-scale square: nearly every point kept, so a long receiver
    // hold-off fills the block and stalls its input
    load_polygon(quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    holdoff_requests++;
    run_points(80);
    set_flow(FLOW_SENDER_IDLE);
    run_points(60);

    // clockwise diamond touching the field edges
    load_polygon(quad(0, -32768, -32768, 0, 0, 32767, 32767, 0));
    set_flow(FLOW_RECEIVER_STALL);
    run_points(80);

    // self-crossing bowtie
    load_polygon(quad(-20000, -20000, 20000, 20000, 20000, -20000, -20000, 20000));
    set_flow(FLOW_BOTH_IDLE);
    run_points(80);

    // no area: all vertices on one spot, then all on one line
    load_polygon(quad(100, 100, 100, 100, 100, 100, 100, 100));
    set_flow(FLOW_SENDER_IDLE);
    run_points(40);
    load_polygon(quad(-1000, -1000, 0, 0, 1000, 1000, 2000, 2000));
    set_flow(FLOW_RECEIVER_STALL);
    run_points(40);

    // random quads at small, medium and full scale
    for (int p = 0; p < 6; p++) begin
      load_polygon(random_quad((p % 3 == 0) ? 1500 : (p % 3 == 1) ? 12000 : 32768));
      set_flow(flow_e'(p % 4));
      run_points(75);
    end

    drain_results();
    $display("%0d points offered across %0d polygon settings, %0d kept points checked",
             points_in, settings_loaded, points_kept);
    $display("included a %0d-cycle receiver hold-off and drains before each setting",
             HOLDOFF_CYCLES);
    if (errors == 0) begin
      $display("point_in_polygon_filter verification clean");
    end else begin
      $display("point_in_polygon_filter verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pip_pkg.sv
design/pip_front.sv
design/pip_queue.sv
design/pip_back.sv
design/point_in_polygon_filter.sv
verif/pip_filter_checker.sv
verif/testbench.sv
